>>> design/ssmp_pkg.sv
// Shared types and constants for the servo motion profiler.
`timescale 1ns / 1ps
`default_nettype none
package ssmp_pkg;
    localparam int unsigned PW_W  = 12;
    localparam int unsigned DUR_W = 16;
    localparam int unsigned LVL_W = 13;
    localparam logic [PW_W-1:0]  PW_RESET      = 12'd1500;
    localparam logic [DUR_W-1:0] DUR_RESET     = 16'd100;
    localparam logic [DUR_W-1:0] DUR_MIN       = 16'd100;
    localparam logic [PW_W-1:0]  MIN_PW_RESET  = 12'd500;
    localparam logic [PW_W-1:0]  MAX_PW_RESET  = 12'd2500;
    localparam logic [DUR_W-1:0] MAX_DUR_RESET = 16'd5000;
    // ceil(2^26 * 39062 / 20000); (pw * LEVEL_MUL) >> 26 is the exact floor for 12-bit pw
    localparam logic [26:0] LEVEL_MUL   = 27'd131070323;
    localparam logic [9:0]  US_PER_MS   = 10'd1000;

    typedef enum logic [1:0] {
        REG_MIN_PW  = 2'd0,
        REG_MAX_PW  = 2'd1,
        REG_MAX_DUR = 2'd2
    } t_reg_idx;

    localparam logic MODE_CMD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [3:0]  servo_select;
        logic [11:0] pw_req;
        logic [15:0] dur_req;
        logic [31:0] time_now_us;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  servo_id;
        logic [12:0] pwm_level;
        logic        still_moving;
        logic        last_of_run;
    } t_out_item;

    function automatic logic [11:0] clamp12(input logic [11:0] v, input logic [11:0] lo,
                                            input logic [11:0] hi);
        logic [11:0] r;
        begin
            if (v < lo) r = lo;
            else if (v > hi) r = hi;
            else r = v;
            return r;
        end
    endfunction
endpackage
`default_nettype wire

>>> design/servo_scurve_motion_profiler.sv
// Top level: configuration registers, front queue and back end.
// Usage: push command or tick items when full is low; results appear as a queue
// (empty/pop). A command is applied and gives no result. A tick walks the
// servos in order: an idle servo is skipped without a result, a servo whose move
// has run out snaps to its target, and an interpolating servo runs through the
// 48-step restoring divider; after each result beat the walk waits for pop.
// The back end takes each item from the front queue only while it is idle.
// A two-entry input queue lets pushes continue while results stall.
// While empty is low and pop is low the result and the walk hold.
// Reset (synchronous, active low) puts all servos idle at 1500 us and loads
// the register defaults 500, 2500 and 5000.
// Configuration writes are taken at any edge with wr_en high.
`timescale 1ns / 1ps
`default_nettype none
module servo_scurve_motion_profiler #(
    parameter int unsigned SERVO_COUNT = 5
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire ssmp_pkg::t_in_item  i_item,
    output logic                     empty,
    input  wire logic                pop,
    output ssmp_pkg::t_out_item      o_item,
    input  wire logic                i_wr_en,
    input  wire logic [1:0]          i_wr_idx,
    input  wire logic [15:0]         i_wr_data
);
    import ssmp_pkg::*;

    logic [11:0] r_min_pw, r_max_pw;
    logic [15:0] r_max_dur;
    logic        w_fv, w_take, w_rv;
    t_in_item    w_fitem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_pw  <= MIN_PW_RESET;
            r_max_pw  <= MAX_PW_RESET;
            r_max_dur <= MAX_DUR_RESET;
        end else if (i_wr_en) begin
            unique case (t_reg_idx'(i_wr_idx))
                REG_MIN_PW:  r_min_pw  <= i_wr_data[11:0];
                REG_MAX_PW:  r_max_pw  <= i_wr_data[11:0];
                REG_MAX_DUR: r_max_dur <= i_wr_data;
                default: ;
            endcase
        end
    end

    ssmp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_in(i_item),
        .o_valid(w_fv), .o_item(w_fitem), .i_take(w_take)
    );

    ssmp_back #(.SERVO_COUNT(SERVO_COUNT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_fv), .i_item(w_fitem),
        .o_take(w_take), .i_min_pw(r_min_pw), .i_max_pw(r_max_pw),
        .i_max_dur(r_max_dur), .o_res_valid(w_rv), .o_res(o_item), .i_res_pop(pop)
    );

    assign empty = !w_rv;
endmodule
`default_nettype wire

>>> design/ssmp_front.sv
// Front end: input acceptance and a two-entry item queue.
`timescale 1ns / 1ps
`default_nettype none
module ssmp_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire ssmp_pkg::t_in_item i_in,
    output logic                   o_valid,
    output ssmp_pkg::t_in_item     o_item,
    input  wire logic              i_take
);
    import ssmp_pkg::*;

    t_in_item   r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign full    = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push && !full) r_q[r_wp] <= i_in;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push && !full) r_wp <= ~r_wp;
            if (i_take && o_valid) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push && !full} - {1'b0, i_take && o_valid};
        end
    end
endmodule
`default_nettype wire

>>> design/ssmp_divider.sv
// Restoring divider: (elapsed << 16) / dur_us, one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module ssmp_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [25:0] i_den,
    output logic             o_done,
    output logic [15:0]      o_quo
);
    logic [47:0] r_num;
    logic [26:0] r_rem;
    logic [15:0] r_quo;
    logic [25:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [26:0] w_sh;
    logic [27:0] w_diff;

    // quotient is known < 2^16, so only the low 16 bits are kept
    assign w_sh   = {r_rem[25:0], r_num[47]};
    assign w_diff = {1'b0, w_sh} - {2'b00, r_den};
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            o_done <= !i_start && r_busy && (r_cnt == 6'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd48;
                r_num  <= {i_num, 16'd0};
                r_den  <= i_den;
                r_rem  <= 27'd0;
                r_quo  <= 16'd0;
            end else if (r_busy) begin
                r_num <= {r_num[46:0], 1'b0};
                if (!w_diff[27]) begin
                    r_rem <= w_diff[26:0];
                    r_quo <= {r_quo[14:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_quo <= {r_quo[14:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) r_busy <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

>>> design/ssmp_back.sv
// Back end: servo state, command execution and the tick walk with easing.
`timescale 1ns / 1ps
`default_nettype none
module ssmp_back #(
    parameter int unsigned SERVO_COUNT = 5
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire ssmp_pkg::t_in_item i_item,
    output logic                    o_take,
    input  wire logic [11:0]        i_min_pw,
    input  wire logic [11:0]        i_max_pw,
    input  wire logic [15:0]        i_max_dur,
    output logic                    o_res_valid,
    output ssmp_pkg::t_out_item     o_res,
    input  wire logic               i_res_pop
);
    import ssmp_pkg::*;
    localparam int unsigned IW = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SCAN = 9'b000000010,
        S_DUR  = 9'b000000100,
        S_DIV  = 9'b000001000,
        S_SQ   = 9'b000010000,
        S_MUL  = 9'b000100000,
        S_POS  = 9'b001000000,
        S_LVL  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_state;
    logic [11:0] r_tgt [SERVO_COUNT];
    logic [11:0] r_spw [SERVO_COUNT];
    logic [11:0] r_cur [SERVO_COUNT];
    logic [15:0] r_mdur [SERVO_COUNT];
    logic [31:0] r_stime [SERVO_COUNT];
    logic [SERVO_COUNT-1:0] r_mov;

    logic [IW-1:0] r_idx;
    logic [31:0]   r_now, r_el;
    logic [25:0]   r_dus;
    logic [16:0]   r_e;
    logic [12:0]   r_delta;
    logic [29:0]   r_prod;
    logic [11:0]   r_pw;
    logic          r_still, r_div_go;
    logic [12:0]   r_lvl;
    logic          r_snap;
    logic [15:0]   w_quo;
    logic          w_done;

    ssmp_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_num(r_el), .i_den(r_dus), .o_done(w_done), .o_quo(w_quo)
    );

    // any moving servo past the walk position
    logic [SERVO_COUNT-1:0] w_rest;
    logic                   w_more;
    always_comb begin
        for (int k = 0; k < SERVO_COUNT; k++)
            w_rest[k] = r_mov[k] && (k > int'(r_idx));
        w_more = |w_rest;
    end

    logic [11:0] w_ctgt;
    logic [15:0] w_cdur;
    logic [15:0] w_q;
    logic [31:0] w_sq;
    logic [12:0] w_mag;
    logic [29:0] w_pm;
    logic [13:0] w_pos;
    logic [11:0] w_pos12;
    logic [38:0] w_lvl;
    always_comb begin
        w_ctgt = clamp12(i_item.pw_req, i_min_pw, i_max_pw);
        if (i_item.dur_req < DUR_MIN) w_cdur = DUR_MIN;
        else if (i_item.dur_req > i_max_dur) w_cdur = i_max_dur;
        else w_cdur = i_item.dur_req;
        w_q  = w_quo[15] ? (16'd0 - w_quo) : w_quo;
        w_sq = {16'd0, w_q} * {16'd0, w_q};
        w_mag = r_delta[12] ? (13'd0 - r_delta) : r_delta;
        w_pm  = {17'd0, w_mag} * {13'd0, r_e};
        if (r_delta[12]) w_pos = {2'b00, r_spw[r_idx]} - {2'b00, r_prod[27:16]};
        else             w_pos = {2'b00, r_spw[r_idx]} + {1'b0, r_prod[28:16]};
        if (w_pos[13]) w_pos12 = 12'd0;
        else if (w_pos[12]) w_pos12 = 12'hFFF;
        else w_pos12 = w_pos[11:0];
        w_lvl = {27'd0, r_pw} * {12'd0, LEVEL_MUL};
    end

    assign o_take = (r_state == S_IDLE) && i_valid;
    assign o_res_valid = (r_state == S_OUT);
    assign o_res.servo_id = 4'(r_idx);
    assign o_res.pwm_level = r_lvl;
    assign o_res.still_moving = r_still;
    assign o_res.last_of_run = !w_more;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mov    <= '0;
            r_idx    <= '0;
            r_div_go <= 1'b0;
            for (int k = 0; k < SERVO_COUNT; k++) begin
                r_tgt[k] <= PW_RESET;
                r_spw[k] <= PW_RESET;
                r_cur[k] <= PW_RESET;
                r_mdur[k] <= DUR_RESET;
                r_stime[k] <= 32'd0;
            end
        end else begin
            r_div_go <= (r_state == S_DUR) && !({6'd0, r_dus} <= r_el);
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_item.mode == MODE_CMD) begin
                            if (32'(i_item.servo_select) < SERVO_COUNT) begin
                                r_tgt[IW'(i_item.servo_select)] <= w_ctgt;
                                r_mdur[IW'(i_item.servo_select)] <= w_cdur;
                                r_spw[IW'(i_item.servo_select)] <=
                                    r_cur[IW'(i_item.servo_select)];
                                r_stime[IW'(i_item.servo_select)] <= i_item.time_now_us;
                                r_mov[IW'(i_item.servo_select)] <= 1'b1;
                            end
                        end else begin
                            r_now   <= i_item.time_now_us;
                            r_idx   <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_mov[r_idx]) begin
                        r_el  <= r_now - r_stime[r_idx];
                        r_dus <= {10'd0, r_mdur[r_idx]} * {16'd0, US_PER_MS};
                        r_state <= S_DUR;
                    end else if (32'(r_idx) + 1 < SERVO_COUNT) begin
                        r_idx <= r_idx + IW'(1);
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DUR: begin
                    r_delta <= {1'b0, r_tgt[r_idx]} - {1'b0, r_spw[r_idx]};
                    if ({6'd0, r_dus} <= r_el) begin
                        r_snap <= 1'b1;
                        r_pw <= r_tgt[r_idx];
                        r_state <= S_LVL;
                    end else begin
                        r_snap <= 1'b0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_done) begin
                        if (!w_quo[15]) r_e <= {2'b00, w_sq[29:15]};
                        else r_e <= 17'h10000 - {1'b0, w_sq[30:15]};
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_prod <= w_pm;
                    r_state <= S_MUL;
                end
                S_MUL: r_state <= S_POS;
                S_POS: begin
                    r_pw <= clamp12(w_pos12, i_min_pw, i_max_pw);
                    r_state <= S_LVL;
                end
                S_LVL: begin
                    r_cur[r_idx] <= r_pw;
                    r_still <= !r_snap;
                    if (r_snap) r_mov[r_idx] <= 1'b0;
                    r_lvl <= w_lvl[38:26];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_res_pop) begin
                        if (w_more) begin
                            r_idx <= r_idx + IW'(1);
                            r_state <= S_SCAN;
                        end else r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> design/ssmp_checker.sv
// Port-level checker for the servo motion profiler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ssmp_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                full,
    input wire logic                empty,
    input wire logic                pop,
    input wire ssmp_pkg::t_out_item o_item
);
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result present after reset");
    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("queue full after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_item)))
        else $error("stalled result changed");
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !$isunknown(o_item))
        else $error("unknown bits in result beat");
endmodule

bind servo_scurve_motion_profiler ssmp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .full(full), .empty(empty), .pop(pop),
    .o_item(o_item)
);
`default_nettype wire
